// ===== rtl/core/pulse_count_code_lock_assert.svh =====
// assertion macros for the pulse count code lock checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PULSE_COUNT_CODE_LOCK_ASSERT_SVH
`define PULSE_COUNT_CODE_LOCK_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PCCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PCCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pccl_pkg.sv =====
// shared types, constants and helpers of the pulse count code lock
// no dependencies
`timescale 1ns / 1ps

package pccl_pkg;

  // highest digit that can be entered
  localparam int MaxCount = 4;
  localparam int CntW     = $clog2(MaxCount + 1);
  localparam int CodeW    = 3;
  localparam int CmpW     = (CntW > CodeW) ? CntW : CodeW;
  localparam int HoldW    = 8;
  localparam int IdleW    = 16;
  localparam int SegW     = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCodeFirst   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCodeSecond  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHoldoff     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegIdleTimeout = 2'd3;

  // configuration reset values
  localparam logic [CodeW-1:0] CodeFirstRst   = 3'd1;
  localparam logic [CodeW-1:0] CodeSecondRst  = 3'd1;
  localparam logic [HoldW-1:0] HoldoffRst     = 8'd10;
  localparam logic [IdleW-1:0] IdleTimeoutRst = 16'd100;

  typedef enum logic [2:0] {
    PhFirst  = 3'd0,
    PhSecond = 3'd1,
    PhCheck  = 3'd2,
    PhRight  = 3'd3,
    PhWrong  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EvNone      = 3'd0,
    EvFirst     = 3'd1,
    EvSecond    = 3'd2,
    EvCorrect   = 3'd3,
    EvWrong     = 3'd4,
    EvEmergency = 3'd5
  } event_e;

  typedef struct packed {
    logic sensor_one_active;
    logic sensor_two_active;
    logic emergency;
  } lock_in_t;

  typedef struct packed {
    logic [2:0]      event_res;
    logic [SegW-1:0] segments;
    logic [2:0]      phase_now;
  } lock_out_t;

  // seven-segment patterns of the digits, bit0 is segment a
  localparam logic [SegW-1:0] DigitPattern [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // pattern of a digit, blank beyond nine
  function automatic logic [SegW-1:0] pattern_of(input logic [3:0] d);
    logic [SegW-1:0] pat;
    pat = '0;
    if (d <= 4'd9) begin
      pat = DigitPattern[d];
    end
    return pat;
  endfunction

endpackage

// ===== rtl/core/pulse_count_code_lock.sv =====
// pulse count code lock: one tick item in, one result item out
// depends on pccl_pkg
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------
// in       | input     | in_valid_i / in_stall_o | in_item_i  (lock_in_t)
// out      | output    | out_valid_o/out_stall_i | out_item_o (lock_out_t)
// cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// each item is worked combinationally and its result is registered, so the
// result shows in the cycle after acceptance; one item per cycle unless stalled;
// in_stall_o is high only while a held result is stalled by out_stall_i
// reset returns the lock to the first digit with a blank display and loads
// the register defaults; no clearing pass is needed
`timescale 1ns / 1ps

module pulse_count_code_lock
  import pccl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lock_in_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lock_out_t           out_item_o
);

  // configuration registers
  logic [CodeW-1:0] code_first_q, code_second_q;
  logic [HoldW-1:0] holdoff_q;
  logic [IdleW-1:0] idle_timeout_q;

  // lock state
  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  first_count_q, first_count_d;
  logic [CntW-1:0]  second_count_q, second_count_d;
  logic [IdleW-1:0] first_idle_q, first_idle_d;
  logic [IdleW-1:0] second_idle_q, second_idle_d;
  logic [HoldW-1:0] first_hold_q, first_hold_d;
  logic [HoldW-1:0] second_hold_q, second_hold_d;
  logic             first_level_q, first_level_d;
  logic             second_level_q, second_level_d;
  logic [SegW-1:0]  pattern_q, pattern_d;
  event_e           event_d;

  // result register
  logic             out_valid_q;
  lock_out_t        out_item_q;
  logic             accept;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_first_q   <= CodeFirstRst;
      code_second_q  <= CodeSecondRst;
      holdoff_q      <= HoldoffRst;
      idle_timeout_q <= IdleTimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCodeFirst:   code_first_q   <= cfg_wdata_i[CodeW-1:0];
        RegCodeSecond:  code_second_q  <= cfg_wdata_i[CodeW-1:0];
        RegHoldoff:     holdoff_q      <= cfg_wdata_i[HoldW-1:0];
        RegIdleTimeout: idle_timeout_q <= cfg_wdata_i[IdleW-1:0];
        default: ;
      endcase
    end
  end

  // next state and event of one tick
  always_comb begin
    logic edge1, edge2, match;

    phase_d        = phase_q;
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    first_idle_d   = first_idle_q;
    second_idle_d  = second_idle_q;
    first_hold_d   = first_hold_q;
    second_hold_d  = second_hold_q;
    first_level_d  = first_level_q;
    second_level_d = second_level_q;
    pattern_d      = pattern_q;
    event_d        = EvNone;
    edge1          = 1'b0;
    edge2          = 1'b0;
    match          = 1'b0;

    if (in_item_i.emergency) begin
      event_d = EvEmergency;
      phase_d = PhFirst;
      first_count_d  = '0;
      second_count_d = '0;
      first_idle_d   = '0;
      second_idle_d  = '0;
      first_hold_d   = '0;
      second_hold_d  = '0;
      first_level_d  = 1'b0;
      second_level_d = 1'b0;
      pattern_d      = '0;
    end else begin
      // debounce counters run down
      if (first_hold_d != '0) first_hold_d = first_hold_d - 1'b1;
      if (second_hold_d != '0) second_hold_d = second_hold_d - 1'b1;

      // edge counting of the active digit
      if (phase_q == PhFirst) begin
        edge1 = in_item_i.sensor_one_active & ~first_level_q & (first_hold_d == '0);
        if (edge1) begin
          if (first_count_d < CntW'(MaxCount)) begin
            first_count_d = first_count_d + 1'b1;
            pattern_d     = pattern_of(4'(first_count_d));
          end
          first_idle_d = '0;
          first_hold_d = holdoff_q;
        end
        if (first_count_d != '0 && first_idle_d != '1) begin
          first_idle_d = first_idle_d + 1'b1;
        end
      end else if (phase_q == PhSecond) begin
        edge2 = in_item_i.sensor_two_active & ~second_level_q & (second_hold_d == '0);
        if (edge2) begin
          if (second_count_d < CntW'(MaxCount)) begin
            second_count_d = second_count_d + 1'b1;
            pattern_d      = pattern_of(4'(second_count_d));
          end
          second_idle_d = '0;
          second_hold_d = holdoff_q;
        end
        if (second_count_d != '0 && second_idle_d != '1) begin
          second_idle_d = second_idle_d + 1'b1;
        end
      end

      first_level_d  = in_item_i.sensor_one_active;
      second_level_d = in_item_i.sensor_two_active;

      // phase sequencing
      case (phase_q)
        PhFirst: begin
          if (first_count_d != '0 && first_idle_d >= idle_timeout_q) begin
            event_d       = EvFirst;
            phase_d       = PhSecond;
            second_idle_d = '0;
          end
        end
        PhSecond: begin
          if (second_count_d != '0 && second_idle_d >= idle_timeout_q) begin
            event_d = EvSecond;
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          match = (CmpW'(first_count_d) == CmpW'(code_first_q)) &&
                  (CmpW'(second_count_d) == CmpW'(code_second_q));
          phase_d = match ? PhRight : PhWrong;
        end
        default: begin
          if (phase_q == PhRight) begin
            event_d = EvCorrect;
          end else if (phase_q == PhWrong) begin
            event_d = EvWrong;
          end
          phase_d        = PhFirst;
          first_count_d  = '0;
          second_count_d = '0;
          first_idle_d   = '0;
          second_idle_d  = '0;
          first_hold_d   = '0;
          second_hold_d  = '0;
          first_level_d  = 1'b0;
          second_level_d = 1'b0;
          pattern_d      = '0;
        end
      endcase
    end
  end

  // state update on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhFirst;
      first_count_q  <= '0;
      second_count_q <= '0;
      first_idle_q   <= '0;
      second_idle_q  <= '0;
      first_hold_q   <= '0;
      second_hold_q  <= '0;
      first_level_q  <= 1'b0;
      second_level_q <= 1'b0;
      pattern_q      <= '0;
    end else if (accept) begin
      phase_q        <= phase_d;
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      first_idle_q   <= first_idle_d;
      second_idle_q  <= second_idle_d;
      first_hold_q   <= first_hold_d;
      second_hold_q  <= second_hold_d;
      first_level_q  <= first_level_d;
      second_level_q <= second_level_d;
      pattern_q      <= pattern_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q.event_res <= event_d;
      out_item_q.segments  <= pattern_d;
      out_item_q.phase_now <= phase_d;
    end
  end

endmodule

// ===== rtl/core/pccl_chk.sv =====
// port-level checker for the pulse count code lock, bound to the top level
// depends on pccl_pkg and pulse_count_code_lock_assert.svh
`timescale 1ns / 1ps

`include "pulse_count_code_lock_assert.svh"

module pccl_chk
  import pccl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input lock_in_t            in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lock_out_t           out_item_o
);

  // a stalled result item holds
  `PCCL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_item_o), "stalled result item changed")

  // an accepted emergency item reports emergency next
  `PCCL_ASSERT_NEXT(a_emg_next, in_valid_i && !in_stall_o && in_item_i.emergency,
    out_valid_o && out_item_o.event_res == EvEmergency, "emergency item not reported")

  // emergency result shows a blank display at the first digit
  `PCCL_ASSERT_NOW(a_emg_blank, out_valid_o && out_item_o.event_res == EvEmergency,
    out_item_o.segments == '0 && out_item_o.phase_now == PhFirst,
    "emergency result not back at start")

  // confirming the first digit moves to the second digit
  `PCCL_ASSERT_NOW(a_first_conf, out_valid_o && out_item_o.event_res == EvFirst,
    out_item_o.phase_now == PhSecond, "first digit confirm without phase change")

  // unlock and wrong results return to start
  `PCCL_ASSERT_NOW(a_verdict_start,
    out_valid_o && (out_item_o.event_res == EvCorrect || out_item_o.event_res == EvWrong),
    out_item_o.segments == '0 && out_item_o.phase_now == PhFirst,
    "verdict result not back at start")

endmodule

bind pulse_count_code_lock pccl_chk u_pccl_chk (.*);
